### src/kftc_pkg.sv
// Shared types and constants for the key frequency threshold counter.
// Used by kftc_hash and key_frequency_threshold_counter; depends on nothing.
`timescale 1ns / 1ps

package kftc_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned COUNT_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [KEY_W-1:0]   HASH_MULT = 32'd2654435761;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage

### src/kftc_hash.sv
// Multiplicative hash of a 32-bit key reduced to a home slot of the table.
// Depends on kftc_pkg for the key width and the hash multiplier.
`timescale 1ns / 1ps

module kftc_hash #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [kftc_pkg::KEY_W-1:0]        key,
  output logic                              done,
  output logic [$clog2(TABLE_ENTRIES)-1:0]  slot
);

  localparam int unsigned IDX_W        = $clog2(TABLE_ENTRIES);
  localparam bit          IS_POW2      = (TABLE_ENTRIES == (1 << IDX_W));
  localparam int unsigned BITS_PER_CYC = 4;
  localparam int unsigned MOD_STEPS    = kftc_pkg::KEY_W / BITS_PER_CYC;
  localparam int unsigned STEP_W       = $clog2(MOD_STEPS);
  localparam logic [IDX_W:0] N_V       = (IDX_W + 1)'(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_MUL  = 4'b0010,
    H_MOD  = 4'b0100,
    H_DONE = 4'b1000
  } hphase_t;

  hphase_t                     phase_r, phase_nxt;
  logic [kftc_pkg::KEY_W-1:0]  prod_r;
  logic [kftc_pkg::KEY_W-1:0]  mix_r;
  logic [IDX_W:0]              rem_r;
  logic [IDX_W:0]              rem_nxt;
  logic [STEP_W-1:0]           step_r;

  // Restoring remainder, a few dividend bits per cycle, most significant first.
  always_comb begin
    rem_nxt = rem_r;
    for (int i = 0; i < BITS_PER_CYC; i++) begin
      rem_nxt = {rem_nxt[IDX_W-1:0], mix_r[kftc_pkg::KEY_W-1-i]};
      if (rem_nxt >= N_V) begin
        rem_nxt = rem_nxt - N_V;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      H_IDLE: if (start) phase_nxt = H_MUL;
      H_MUL:  phase_nxt = IS_POW2 ? H_DONE : H_MOD;
      H_MOD:  if (step_r == STEP_W'(MOD_STEPS - 1)) phase_nxt = H_DONE;
      H_DONE: phase_nxt = H_IDLE;
      default: phase_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= H_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == H_IDLE && start) begin
      prod_r <= key * kftc_pkg::HASH_MULT;
    end
    if (phase_r == H_MUL) begin
      mix_r  <= prod_r ^ (prod_r >> 16);
      rem_r  <= '0;
      step_r <= '0;
    end
    if (phase_r == H_MOD) begin
      mix_r  <= mix_r << BITS_PER_CYC;
      rem_r  <= rem_nxt;
      step_r <= step_r + STEP_W'(1);
    end
  end

  assign done = (phase_r == H_DONE);
  assign slot = IS_POW2 ? mix_r[IDX_W-1:0] : rem_r[IDX_W-1:0];

endmodule

### src/key_frequency_threshold_counter.sv
// Top level of the key frequency threshold counter: hash table memory and control.
// Depends on kftc_pkg and instantiates kftc_hash.
`timescale 1ns / 1ps

// This block counts how often each signed 32-bit key occurs in a hash table of
// TABLE_ENTRIES slots with linear probing. Opcode 0 counts a key (inserting it
// with count 1, or adding one and saturating at 65535), opcode 1 queries a key
// and returns one result transaction with its count, whether the count reaches
// the min_occurrences threshold, and the table overflow flag; opcode 2 empties
// the table and clears the overflow flag; opcode 3 is ignored. Only queries
// produce results. One item is handled at a time. A count or query whose key
// sits in its home slot passes through one hash multiply, one hash mix, then a
// read and a compare-and-write on the single table memory (a query writes
// nothing and waits in the compare until the output register frees). Each
// further probe along the chain adds a read and then a compare. When
// TABLE_ENTRIES is not a power of two, the slot reduction runs in a
// four-bits-per-cycle remainder unit. The table is emptied by a clearing
// pass over the memory, one entry per cycle, after reset and after every
// clear transaction; input is not accepted during the pass, while
// configuration writes always are. The threshold register must only be
// written while no item is in progress.
module key_frequency_threshold_counter #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_min_occurrences,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_key,

  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_query_key,
  output logic [15:0]        out_occurrences,
  output logic               out_qualifies,
  output logic               out_table_overflowed
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_READ  = 5'b01000,
    S_CMP   = 5'b10000
  } state_t;

  state_t                              state_r, state_nxt;
  kftc_pkg::opcode_t                   op_r;
  kftc_pkg::opcode_t                   in_op;
  logic [kftc_pkg::KEY_W-1:0]          key_r;
  logic [IDX_W-1:0]                    slot_r;
  logic [IDX_W-1:0]                    step_r;
  logic [IDX_W-1:0]                    clr_idx_r;
  logic                                overflow_r;
  logic [kftc_pkg::COUNT_W-1:0]        min_occ_r;

  // Table memory: one synchronous write port, one registered read port.
  kftc_pkg::entry_t                    mem [TABLE_ENTRIES];
  kftc_pkg::entry_t                    rd_q;
  logic                                rd_en;
  logic                                wr_en;
  logic [IDX_W-1:0]                    wr_addr;
  kftc_pkg::entry_t                    wr_data;

  logic                                in_fire;
  logic                                hash_start;
  logic                                hash_done;
  logic [IDX_W-1:0]                    hash_slot;

  logic                                hit;
  logic                                empty;
  logic                                chain_end;
  logic                                out_free;
  logic                                out_load;
  logic [kftc_pkg::COUNT_W-1:0]        count_inc;

  logic                                out_valid_r;
  logic [kftc_pkg::KEY_W-1:0]          out_key_r;
  logic [kftc_pkg::COUNT_W-1:0]        out_occ_r;
  logic                                out_qual_r;
  logic                                out_ovf_r;

  assign in_op      = kftc_pkg::opcode_t'(in_opcode);
  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign hash_start = in_fire && (in_op == kftc_pkg::OP_COUNT || in_op == kftc_pkg::OP_QUERY);
  assign cfg_ready  = 1'b1;

  kftc_hash #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_hash (
    .clk  (clk),
    .rst_n(rst_n),
    .start(hash_start),
    .key  (in_key),
    .done (hash_done),
    .slot (hash_slot)
  );

  // The probe either lands on an empty slot, on the key itself, or runs
  // through every slot of the table without finding either.
  assign empty     = !rd_q.valid;
  assign hit       = rd_q.valid && (rd_q.key == key_r);
  assign chain_end = empty || hit || (step_r == LAST_IDX);
  assign count_inc = (rd_q.count == kftc_pkg::COUNT_MAX) ? rd_q.count
                                                         : rd_q.count + 1'b1;

  // A finished query waits in the compare state until the output register frees.
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == S_CMP) && (op_r == kftc_pkg::OP_QUERY) && chain_end
                    && out_free;

  assign rd_en = (state_r == S_READ);

  // The clearing pass and the count update share the write port; they never
  // happen in the same cycle.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_r;
    wr_data = '0;
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_r;
    end else if (state_r == S_CMP && op_r == kftc_pkg::OP_COUNT && (empty || hit)) begin
      wr_en         = 1'b1;
      wr_data.valid = 1'b1;
      wr_data.key   = key_r;
      wr_data.count = hit ? count_inc : kftc_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[slot_r];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_idx_r == LAST_IDX) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            kftc_pkg::OP_COUNT, kftc_pkg::OP_QUERY: state_nxt = S_HASH;
            kftc_pkg::OP_CLEAR:                     state_nxt = S_CLEAR;
            kftc_pkg::OP_NONE:                      state_nxt = S_IDLE;
            default:                                state_nxt = S_IDLE;
          endcase
        end
      end
      S_HASH: if (hash_done) state_nxt = S_READ;
      S_READ: state_nxt = S_CMP;
      S_CMP: begin
        if (!chain_end) begin
          state_nxt = S_READ;
        end else if (op_r == kftc_pkg::OP_COUNT || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      overflow_r  <= 1'b0;
      min_occ_r   <= kftc_pkg::COUNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        min_occ_r <= cfg_min_occurrences;
      end
      if (state_r == S_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (in_fire && in_op == kftc_pkg::OP_CLEAR) begin
        clr_idx_r  <= '0;
        overflow_r <= 1'b0;
      end
      if (state_r == S_CMP && op_r == kftc_pkg::OP_COUNT && !empty && !hit
          && step_r == LAST_IDX) begin
        overflow_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_op;
      key_r <= in_key;
    end
    if (state_r == S_HASH && hash_done) begin
      slot_r <= hash_slot;
      step_r <= '0;
    end
    if (state_r == S_CMP && !chain_end) begin
      slot_r <= (slot_r == LAST_IDX) ? '0 : slot_r + 1'b1;
      step_r <= step_r + 1'b1;
    end
    if (out_load) begin
      out_key_r  <= key_r;
      out_occ_r  <= hit ? rd_q.count : '0;
      out_qual_r <= hit && (rd_q.count >= min_occ_r);
      out_ovf_r  <= overflow_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_query_key        = $signed(out_key_r);
  assign out_occurrences      = out_occ_r;
  assign out_qualifies        = out_qual_r;
  assign out_table_overflowed = out_ovf_r;

`ifndef ASSERT_OFF
  // The table is written only by the clearing pass and by the end of a count probe.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_CLEAR || (state_r == S_CMP && op_r == kftc_pkg::OP_COUNT)))
    else $error("table written outside the clearing pass or a count update");

  // The hash unit reports a slot only while the controller waits for it.
  a_hash_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> state_r == S_HASH)
    else $error("hash result arrived outside the hash wait state");

  // The overflow flag only rises at the end of a count probe that found no room.
  a_overflow_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(overflow_r) |-> $past(state_r == S_CMP && op_r == kftc_pkg::OP_COUNT))
    else $error("overflow flag set outside a count probe");

  // A clear transaction starts the pass at entry zero with the flag cleared.
  a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op == kftc_pkg::OP_CLEAR) |=>
      (state_r == S_CLEAR && clr_idx_r == '0 && !overflow_r))
    else $error("clear transaction did not start a clearing pass");

  // A new result is never loaded over one that has not been taken.
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !out_load)
    else $error("result register overwritten while stalled");
`endif

endmodule
